// File: hw/rtl/lcwh_pkg.sv
`default_nettype none

package lcwh_pkg;

  // histogram geometry
  localparam int CountBits = 32;
  localparam int Bins      = 256;
  localparam int BinW      = $clog2(Bins);
  localparam int NumLanes  = 4;
  localparam int OutCntW   = 32;

  // luma sum width and divide-by-100 reciprocal (exact for sums below 2^15)
  localparam int SumW       = 15;
  localparam int RecipMul   = 5243;
  localparam int RecipW     = 13;
  localparam int RecipShift = 19;
  localparam int ProdW      = SumW + RecipW;
  localparam int QuoW       = ProdW - RecipShift;

  // output queue
  localparam int QDepth = 8;
  localparam int QAw    = $clog2(QDepth);
  localparam int OccW   = $clog2(QDepth + 1);

  typedef logic [CountBits-1:0] cnt_t;

  typedef enum logic {
    OpPixel = 1'b0,
    OpRead  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    SelRed   = 2'd0,
    SelGreen = 2'd1,
    SelBlue  = 2'd2,
    SelOut   = 2'd3
  } hist_sel_e;

  typedef enum logic {
    CfgColour = 1'b0,
    CfgInvert = 1'b1
  } cfg_idx_e;

  // one accepted item
  typedef struct packed {
    op_e             op;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    hist_sel_e       sel;
    logic [BinW-1:0] idx;
  } item_t;

  // item at the end of the luma pipeline
  typedef struct packed {
    logic            vld;
    op_e             op;
    hist_sel_e       sel;
    logic [BinW-1:0] idx;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      gray;
  } luma_t;

  // read-modify-write request into one histogram lane
  typedef struct packed {
    logic            vld;
    logic            inc;
    logic [BinW-1:0] addr;
  } lane_req_t;

  typedef struct packed {
    logic [OutCntW-1:0] bin_count;
    logic [7:0]         gray_out;
  } res_t;

  // clip a counter to the 32-bit result field
  function automatic logic [OutCntW-1:0] sat_out(cnt_t c);
    logic [63:0] w;
    w = 64'(c);
    if (|w[63:OutCntW]) begin
      return '1;
    end
    return w[OutCntW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lcwh_luma.sv
`default_nettype none

module lcwh_luma
  import lcwh_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_vld_i,
  input  wire item_t item_i,
  input  wire logic  colour_i,
  input  wire logic  invert_i,
  output luma_t      s3_o
);

  logic            s1_vld_q, s2_vld_q, s3_vld_q;
  item_t           s1_q, s2_q, s3_q;
  logic [SumW-1:0] sum_d, sum_q;
  logic [ProdW-1:0] prod;
  logic [QuoW-1:0] quo_d, quo_q;
  logic [7:0]      lum, pre;

  // weighted sum of the three samples
  assign sum_d = SumW'(s1_q.red   * SumW'(30))
               + SumW'(s1_q.green * SumW'(59))
               + SumW'(s1_q.blue  * SumW'(11));

  // divide by 100 through the reciprocal
  assign prod  = ProdW'(sum_q) * ProdW'(RecipMul);
  assign quo_d = prod[ProdW-1:RecipShift];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    s1_q  <= item_i;
    s2_q  <= s1_q;
    sum_q <= sum_d;
    s3_q  <= s2_q;
    quo_q <= quo_d;
  end

  // clamp, mode select and optional inversion
  always_comb begin
    lum = (quo_q > QuoW'(255)) ? 8'hFF : quo_q[7:0];
    pre = colour_i ? lum : s3_q.red;
    s3_o.vld   = s3_vld_q;
    s3_o.op    = s3_q.op;
    s3_o.sel   = s3_q.sel;
    s3_o.idx   = s3_q.idx;
    s3_o.red   = s3_q.red;
    s3_o.green = s3_q.green;
    s3_o.blue  = s3_q.blue;
    s3_o.gray  = invert_i ? ~pre : pre;
  end

endmodule

`default_nettype wire

// File: hw/rtl/lcwh_lane.sv
`default_nettype none

module lcwh_lane
  import lcwh_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            clr_i,
  input  wire logic [BinW-1:0] clr_addr_i,
  input  wire lane_req_t       req_i,
  output cnt_t                 cnt_o
);

  cnt_t            mem [Bins];
  cnt_t            rdata_q;
  logic            b_vld_q, b_inc_q;
  logic [BinW-1:0] b_addr_q;
  logic            fwd_hit_d, fwd_hit_q;
  cnt_t            fwd_data_q;
  cnt_t            old_cnt, new_cnt;
  logic            wr_en;
  logic [BinW-1:0] wr_addr;
  cnt_t            wr_data;

  // count as seen by the item in the write-back stage
  assign old_cnt = fwd_hit_q ? fwd_data_q : rdata_q;
  assign new_cnt = (&old_cnt) ? old_cnt : old_cnt + 1'b1;
  assign cnt_o   = old_cnt;

  // the write landing this edge is invisible to the read of the same edge
  assign fwd_hit_d = req_i.vld && b_vld_q && b_inc_q && (req_i.addr == b_addr_q);

  // clearing pass or saturating increment
  always_comb begin
    wr_en   = clr_i || (b_vld_q && b_inc_q);
    wr_addr = clr_i ? clr_addr_i : b_addr_q;
    wr_data = clr_i ? '0 : new_cnt;
  end

  // bin memory
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-back stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      b_vld_q   <= req_i.vld;
      fwd_hit_q <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_inc_q    <= req_i.inc;
    b_addr_q   <= req_i.addr;
    fwd_data_q <= new_cnt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/lcwh_merge.sv
`default_nettype none

module lcwh_merge
  import lcwh_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire luma_t s3_i,
  input  wire cnt_t  cnt_i [NumLanes],
  output logic       res_vld_o,
  output res_t       res_o
);

  logic       s4_vld_q;
  op_e        s4_op_q;
  hist_sel_e  s4_sel_q;
  logic [7:0] s4_gray_q;
  cnt_t       pick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_op_q   <= s3_i.op;
    s4_sel_q  <= s3_i.sel;
    s4_gray_q <= s3_i.gray;
  end

  // choose the lane the read asked for
  always_comb begin
    unique case (s4_sel_q)
      SelRed:   pick = cnt_i[0];
      SelGreen: pick = cnt_i[1];
      SelBlue:  pick = cnt_i[2];
      SelOut:   pick = cnt_i[3];
      default:  pick = cnt_i[0];
    endcase
  end

  // pixels carry gray, reads carry a count
  always_comb begin
    res_vld_o = s4_vld_q;
    if (s4_op_q == OpRead) begin
      res_o.gray_out  = '0;
      res_o.bin_count = sat_out(pick);
    end else begin
      res_o.gray_out  = s4_gray_q;
      res_o.bin_count = '0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lcwh_outq.sv
`default_nettype none

module lcwh_outq
  import lcwh_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t data_i,
  input  wire logic pop_i,
  output logic      vld_o,
  output res_t      data_o
);

  res_t           q [QDepth];
  logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [OccW-1:0] cnt_q;

  assign vld_o  = (cnt_q != '0);
  assign data_o = q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i && vld_o) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + OccW'(push_i) - OccW'(pop_i && vld_o);
    end
  end

  // the credit scheme upstream must never overfill the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < OccW'(QDepth)))
    else $error("result pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !(pop_i && vld_o)) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue fill level lost a push");

endmodule

`default_nettype wire

// File: hw/rtl/luma_convert_with_histograms.sv
`default_nettype none

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: red, green, blue, bin_index
//                                               tuser: operation, histogram_select
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: gray_out, bin_count
// cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// one item per clock sustained while m_axis_tready holds; a result is first offered once
// its item has passed two more luma stages, the bin-memory read and the result queue write.
// four histogram lanes do read-modify-write in parallel, adjacent hits are forwarded.
// after reset a clearing pass zeroes all 256 bins; no item is taken then.
// m_axis stalls are absorbed by an 8-entry result queue; s_axis_tready drops
// once 8 items are in flight or queued; cfg_ready_o waits until none are.
module luma_convert_with_histograms
  import lcwh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // red[7:0] green[15:8] blue[23:16] bin_index[31:24]
  input  wire logic [2:0]  s_axis_tuser,  // operation[0] histogram_select[2:1]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // gray_out[7:0] bin_count[39:8]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic        cfg_data_i
);

  logic            colour_q, invert_q;
  logic            clr_q;
  logic [BinW-1:0] clr_addr_q;
  logic [OccW-1:0] occ_q;
  logic            in_acc, out_acc;
  item_t           item;
  luma_t           s3;
  lane_req_t       req [NumLanes];
  cnt_t            cnt [NumLanes];
  logic            res_vld;
  res_t            res, q_data;
  logic            is_pix;

  // configuration registers, written only with no item in flight
  assign cfg_ready_o = (occ_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q <= 1'b1;
      invert_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgColour: colour_q <= cfg_data_i;
        CfgInvert: invert_q <= cfg_data_i;
        default:   colour_q <= colour_q;
      endcase
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clr_q <= 1'b0;
      end
    end
  end

  // credit for every item until its result leaves
  assign s_axis_tready = !clr_q && (occ_q < OccW'(QDepth));
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + OccW'(in_acc) - OccW'(out_acc);
    end
  end

  // unpack the item
  always_comb begin
    item.op    = op_e'(s_axis_tuser[0]);
    item.sel   = hist_sel_e'(s_axis_tuser[2:1]);
    item.red   = s_axis_tdata[7:0];
    item.green = s_axis_tdata[15:8];
    item.blue  = s_axis_tdata[23:16];
    item.idx   = s_axis_tdata[31:24];
  end

  lcwh_luma u_luma (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (in_acc),
    .item_i   (item),
    .colour_i (colour_q),
    .invert_i (invert_q),
    .s3_o     (s3)
  );

  // lane requests: reads look up the bin, pixels bump their sample's bin (green/blue only in colour mode)
  always_comb begin
    is_pix = (s3.op == OpPixel);
    for (int i = 0; i < NumLanes; i++) begin
      req[i].vld = s3.vld;
    end
    req[0].addr = is_pix ? s3.red   : s3.idx;
    req[1].addr = is_pix ? s3.green : s3.idx;
    req[2].addr = is_pix ? s3.blue  : s3.idx;
    req[3].addr = is_pix ? s3.gray  : s3.idx;
    req[0].inc  = is_pix;
    req[1].inc  = is_pix && colour_q;
    req[2].inc  = is_pix && colour_q;
    req[3].inc  = is_pix;
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    lcwh_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clr_i      (clr_q),
      .clr_addr_i (clr_addr_q),
      .req_i      (req[g]),
      .cnt_o      (cnt[g])
    );
  end

  lcwh_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s3_i      (s3),
    .cnt_i     (cnt),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  lcwh_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_vld),
    .data_i (res),
    .pop_i  (m_axis_tready),
    .vld_o  (m_axis_tvalid),
    .data_o (q_data)
  );

  assign m_axis_tdata = {q_data.bin_count, q_data.gray_out};

  // items in flight never exceed the queue space reserved for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(QDepth))
    else $error("item credit overrun");

  // no histogram traffic while the bins are being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (!in_acc && !s3.vld))
    else $error("item entered during clearing pass");

endmodule

`default_nettype wire
